// File: src/tcpra_pkg.sv
package tcpra_pkg;

   localparam int OooDepth     = 16;
   localparam int InorderDepth = 16;
   localparam int OooIdxW      = $clog2(OooDepth);
   localparam int InoIdxW      = $clog2(InorderDepth);
   localparam int OooCntW      = $clog2(OooDepth + 1);
   localparam int InoCntW      = $clog2(InorderDepth + 1);

   localparam logic [2:0] StInOrder   = 3'd0;
   localparam logic [2:0] StQueued    = 3'd1;
   localparam logic [2:0] StWinClosed = 3'd2;
   localparam logic [2:0] StDuplicate = 3'd3;
   localparam logic [2:0] StOverlap   = 3'd4;
   localparam logic [2:0] StReadDone  = 3'd5;
   localparam logic [2:0] StFull      = 3'd6;

   localparam logic OpSegment = 1'b0;
   localparam logic OpRead    = 1'b1;

   localparam logic RegInitialSeq = 1'b0;
   localparam logic RegWindow     = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture the request beat
      logic ino_append;  // append the captured segment to the in-order queue
      logic scan_step;   // examine one out-of-order entry
      logic ins_start;   // remember the insert slot and start the walk at the top
      logic ins_shift;   // move one out-of-order entry up by one
      logic ins_write;   // write the segment at the insert position
      logic drain_pop;   // move the head out-of-order entry to the in-order queue
      logic drain_shift; // shift the out-of-order table down by one
      logic read_step;   // consume from the head of the in-order queue
      logic read_shift;  // shift the in-order queue down by one
      logic set_status;
      logic [2:0] status;
   } tcpra_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op;
      logic win_zero;
      logic seq_match;
      logic ino_full;
      logic ooo_full;
      logic scan_done;   // scan reached the end of the table
      logic scan_dup;
      logic scan_ovl;
      logic scan_before; // segment sorts before the scanned entry
      logic shift_done;
      logic drain_ok;    // head entry is contiguous and queue has room
      logic read_more;   // queue nonempty and budget left
      logic head_empty;  // head entry would be fully consumed
      logic read_shift_done;
   } tcpra_sts_type;

endpackage

// File: src/tcpra_ctrl.sv
module tcpra_ctrl
   import tcpra_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  tcpra_sts_type sts,
   output tcpra_cmd_type cmd
);

   typedef enum logic [3:0] {
      IDLE, DECIDE, SCAN, INS_SHIFT, INS_WRITE, DRAIN, DRAIN_SHIFT,
      READ, READ_SHIFT, DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = DECIDE;
            end
         end
         DECIDE: begin
            if (sts.op == OpRead) begin
               state_in = READ;
            end else if (sts.win_zero) begin
               cmd.set_status = 1'b1;
               cmd.status     = StWinClosed;
               state_in       = DONE;
            end else if (sts.seq_match) begin
               cmd.set_status = 1'b1;
               if (sts.ino_full) begin
                  cmd.status = StFull;
                  state_in   = DONE;
               end else begin
                  cmd.status     = StInOrder;
                  cmd.ino_append = 1'b1;
                  state_in       = DRAIN;
               end
            end else begin
               state_in = SCAN;
            end
         end
         SCAN: begin
            if (sts.scan_done || sts.scan_before) begin
               if (sts.scan_before && sts.scan_ovl) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = StOverlap;
                  state_in       = DONE;
               end else if (sts.ooo_full) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = StFull;
                  state_in       = DONE;
               end else begin
                  cmd.ins_start = 1'b1;
                  state_in      = INS_SHIFT;
               end
            end else if (sts.scan_dup) begin
               cmd.set_status = 1'b1;
               cmd.status     = StDuplicate;
               state_in       = DONE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         INS_SHIFT: begin
            if (sts.shift_done) begin
               state_in = INS_WRITE;
            end else begin
               cmd.ins_shift = 1'b1;
            end
         end
         INS_WRITE: begin
            cmd.ins_write  = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = StQueued;
            state_in       = DONE;
         end
         DRAIN: begin
            if (sts.drain_ok) begin
               cmd.drain_pop = 1'b1;
               state_in      = DRAIN_SHIFT;
            end else begin
               state_in = DONE;
            end
         end
         DRAIN_SHIFT: begin
            if (sts.shift_done) begin
               state_in = DRAIN;
            end else begin
               cmd.drain_shift = 1'b1;
            end
         end
         READ: begin
            if (sts.read_more) begin
               cmd.read_step = 1'b1;
               if (sts.head_empty) begin
                  state_in = READ_SHIFT;
               end
            end else begin
               cmd.set_status = 1'b1;
               cmd.status     = StReadDone;
               state_in       = DONE;
            end
         end
         READ_SHIFT: begin
            if (sts.read_shift_done) begin
               state_in = READ;
            end else begin
               cmd.read_shift = 1'b1;
            end
         end
         DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_one_job: assert property (@(posedge clock) disable iff (reset)
      (state_ff != IDLE) |-> !req_ready)
      else $error("request taken while busy");
   a_done_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DONE) |=> rsp_valid)
      else $error("finished job produced no response");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == DECIDE))
      else $error("load did not start decode");

endmodule

// File: src/tcpra_dp.sv
module tcpra_dp
   import tcpra_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_op,
   input  logic [31:0]   req_seg_seq,
   input  logic [15:0]   req_seg_len,
   input  logic          req_seg_push,
   input  logic [15:0]   req_read_budget,
   input  logic          cfg_wr,
   input  logic          cfg_idx,
   input  logic [31:0]   cfg_wdata,
   output logic [31:0]   cfg_seq,
   output logic [15:0]   cfg_win,
   input  tcpra_cmd_type cmd,
   output tcpra_sts_type sts,
   output logic [2:0]    rsp_status,
   output logic [31:0]   rsp_next_expected,
   output logic [15:0]   rsp_bytes_read,
   output logic          rsp_push_seen,
   output logic          rsp_data_ready,
   output logic [4:0]    rsp_ooo_count
);

   logic [31:0] init_seq_ff;
   logic [15:0] window_ff;
   logic [31:0] exp_ff;
   logic [OooCntW-1:0] ooo_used_ff;
   logic [InoCntW-1:0] ino_used_ff;
   logic push_flag_ff;
   logic [2:0] status_ff;
   logic [15:0] taken_ff;

   logic op_ff, push_ff;
   logic [31:0] seq_ff;
   logic [15:0] len_ff, budget_ff;

   logic [31:0] ooo_start_ff [OooDepth];
   logic [15:0] ooo_len_ff   [OooDepth];
   logic        ooo_push_ff  [OooDepth];
   logic [15:0] ino_len_ff   [InorderDepth];
   logic        ino_push_ff  [InorderDepth];

   // Walk pointer shared by scan, insert shift and drain shift.
   logic [OooCntW-1:0] ptr_ff;
   logic [OooCntW-1:0] pos_ff;
   logic [InoCntW-1:0] rptr_ff;

   logic [OooIdxW-1:0] ptr_idx, pm1_idx;
   logic [31:0] ent_start;
   logic [32:0] seg_end;
   logic [15:0] head_len, remain, d;

   assign ptr_idx   = ptr_ff[OooIdxW-1:0];
   assign pm1_idx   = OooIdxW'(ptr_ff - OooCntW'(1));
   assign ent_start = ooo_start_ff[ptr_idx];
   assign seg_end   = {1'b0, seq_ff} + {17'd0, len_ff};
   assign head_len  = ino_len_ff[0];
   assign remain    = budget_ff - taken_ff;
   assign d         = (head_len < remain) ? head_len : remain;

   always_comb begin
      sts                 = '0;
      sts.op              = op_ff;
      sts.win_zero        = (window_ff == 16'd0);
      sts.seq_match       = (seq_ff == exp_ff);
      sts.ino_full        = (ino_used_ff == InoCntW'(InorderDepth));
      sts.ooo_full        = (ooo_used_ff == OooCntW'(OooDepth));
      sts.scan_done       = (ptr_ff >= ooo_used_ff);
      sts.scan_dup        = (seq_ff == ent_start);
      sts.scan_before     = !sts.scan_done && (seq_ff < ent_start);
      sts.scan_ovl        = seg_end > {1'b0, ent_start};
      sts.shift_done      = (ptr_ff == pos_ff);
      sts.drain_ok        = (ooo_used_ff != '0) && (ooo_start_ff[0] == exp_ff) &&
                            !sts.ino_full;
      sts.read_more       = (ino_used_ff != '0) && (taken_ff < budget_ff);
      sts.head_empty      = (head_len == d);
      // The count already excludes the popped head, so it is the number of moves.
      sts.read_shift_done = (rptr_ff >= ino_used_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_seq_ff  <= '0;
         window_ff    <= 16'hFFFF;
         exp_ff       <= '0;
         ooo_used_ff  <= '0;
         ino_used_ff  <= '0;
         push_flag_ff <= 1'b0;
      end else begin
         if (cfg_wr) begin
            if (cfg_idx == RegInitialSeq) begin
               init_seq_ff <= cfg_wdata;
               exp_ff      <= cfg_wdata;
            end else begin
               window_ff <= cfg_wdata[15:0];
            end
         end
         if (cmd.ino_append) begin
            exp_ff      <= exp_ff + {16'd0, len_ff};
            ino_used_ff <= ino_used_ff + InoCntW'(1);
         end
         if (cmd.ins_write) begin
            ooo_used_ff <= ooo_used_ff + OooCntW'(1);
         end
         if (cmd.drain_pop) begin
            exp_ff      <= exp_ff + {16'd0, ooo_len_ff[0]};
            ino_used_ff <= ino_used_ff + InoCntW'(1);
            ooo_used_ff <= ooo_used_ff - OooCntW'(1);
         end
         if (cmd.read_step && (head_len == d)) begin
            ino_used_ff <= ino_used_ff - InoCntW'(1);
            if (ino_push_ff[0]) begin
               push_flag_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_op;
         seq_ff    <= req_seg_seq;
         len_ff    <= req_seg_len;
         push_ff   <= req_seg_push;
         budget_ff <= req_read_budget;
         taken_ff  <= '0;
         ptr_ff    <= '0;
         rptr_ff   <= '0;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.ino_append) begin
         ino_len_ff[ino_used_ff[InoIdxW-1:0]]  <= len_ff;
         ino_push_ff[ino_used_ff[InoIdxW-1:0]] <= push_ff;
      end
      if (cmd.scan_step) begin
         ptr_ff <= ptr_ff + OooCntW'(1);
      end
      // Scan found its slot: remember it and walk down from the free slot above the top entry.
      if (cmd.ins_start) begin
         pos_ff <= ptr_ff;
         ptr_ff <= ooo_used_ff;
      end
      if (cmd.ins_shift) begin
         ooo_start_ff[ptr_idx] <= ooo_start_ff[pm1_idx];
         ooo_len_ff[ptr_idx]   <= ooo_len_ff[pm1_idx];
         ooo_push_ff[ptr_idx]  <= ooo_push_ff[pm1_idx];
         ptr_ff <= ptr_ff - OooCntW'(1);
      end
      if (cmd.ins_write) begin
         ooo_start_ff[ptr_idx] <= seq_ff;
         ooo_len_ff[ptr_idx]   <= len_ff;
         ooo_push_ff[ptr_idx]  <= push_ff;
      end
      if (cmd.drain_pop) begin
         ino_len_ff[ino_used_ff[InoIdxW-1:0]]  <= ooo_len_ff[0];
         ino_push_ff[ino_used_ff[InoIdxW-1:0]] <= ooo_push_ff[0];
         ptr_ff <= '0;
         pos_ff <= ooo_used_ff - OooCntW'(1);
      end
      if (cmd.drain_shift) begin
         ooo_start_ff[ptr_idx] <= ooo_start_ff[OooIdxW'(ptr_ff + OooCntW'(1))];
         ooo_len_ff[ptr_idx]   <= ooo_len_ff[OooIdxW'(ptr_ff + OooCntW'(1))];
         ooo_push_ff[ptr_idx]  <= ooo_push_ff[OooIdxW'(ptr_ff + OooCntW'(1))];
         ptr_ff <= ptr_ff + OooCntW'(1);
      end
      if (cmd.read_step) begin
         taken_ff      <= taken_ff + d;
         ino_len_ff[0] <= head_len - d;
         rptr_ff       <= '0;
      end
      if (cmd.read_shift) begin
         ino_len_ff[rptr_ff[InoIdxW-1:0]]  <= ino_len_ff[InoIdxW'(rptr_ff + InoCntW'(1))];
         ino_push_ff[rptr_ff[InoIdxW-1:0]] <= ino_push_ff[InoIdxW'(rptr_ff + InoCntW'(1))];
         rptr_ff <= rptr_ff + InoCntW'(1);
      end
   end

   assign cfg_seq           = init_seq_ff;
   assign cfg_win           = window_ff;
   assign rsp_status        = status_ff;
   assign rsp_next_expected = exp_ff;
   assign rsp_bytes_read    = taken_ff;
   assign rsp_push_seen     = push_flag_ff;
   assign rsp_data_ready    = (ino_used_ff != '0);
   assign rsp_ooo_count     = 5'(ooo_used_ff);

endmodule

// File: src/tcp_receive_reassembly_top.sv
// TCP receive reassembly on segment descriptors.
// Request channel (req_*): op 0 is a segment arrival (seq, len, push), op 1 is
// a read request with a byte budget. Each request beat yields one response
// beat (rsp_*) with a status code, the next expected sequence number, bytes
// read, the sticky push flag, whether in-order data is pending, and the
// number of out-of-order entries held.
// One request is processed at a time, and the table walks move one entry per
// cycle. A closed window or a full in-order queue is answered straight after
// decode. An in-order segment is appended, then each contiguous out-of-order
// entry is drained into the in-order queue and the table shifted down. Any
// other segment is scanned against the table and dropped (duplicate, overlap
// or full table), or inserted after the entries above its slot move up. A read
// consumes from the head of the in-order queue until the budget is spent or
// the queue is empty, shifting the queue down after each entry fully consumed.
// The response is held in an output register until rsp_ready; the next request
// beat is taken at the earliest in the cycle after the response beat leaves.
// Reset clears both tables' counts, the push flag and the expected number,
// and sets the receive window to 65535. Configuration is written through the
// csr_ port; the user must write it only while the block is idle, which the
// block itself does not enforce. Writing initial_sequence also reloads the
// expected sequence number.
module tcp_receive_reassembly_top
   import tcpra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [31:0] req_seg_seq,
   input  logic [15:0] req_seg_len,
   input  logic        req_seg_push,
   input  logic [15:0] req_read_budget,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_next_expected,
   output logic [15:0] rsp_bytes_read,
   output logic        rsp_push_seen,
   output logic        rsp_data_ready,
   output logic [4:0]  rsp_ooo_count,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   tcpra_cmd_type cmd;
   tcpra_sts_type sts;
   logic [31:0]   cfg_seq;
   logic [15:0]   cfg_win;
   logic          cfg_wr;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == RegInitialSeq) ? cfg_seq : {16'd0, cfg_win};

   tcpra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tcpra_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_op            (req_op),
      .req_seg_seq       (req_seg_seq),
      .req_seg_len       (req_seg_len),
      .req_seg_push      (req_seg_push),
      .req_read_budget   (req_read_budget),
      .cfg_wr            (cfg_wr),
      .cfg_idx           (csr_paddr[2]),
      .cfg_wdata         (csr_pwdata),
      .cfg_seq           (cfg_seq),
      .cfg_win           (cfg_win),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_status        (rsp_status),
      .rsp_next_expected (rsp_next_expected),
      .rsp_bytes_read    (rsp_bytes_read),
      .rsp_push_seen     (rsp_push_seen),
      .rsp_data_ready    (rsp_data_ready),
      .rsp_ooo_count     (rsp_ooo_count)
   );

endmodule
